>>> hw/rtl/sps_pkg.sv
package sps_pkg;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned COIL_W     = 4;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0]   POS_MAX         = 8'd255;
  localparam logic [POS_W-1:0]   POS_MIN         = 8'd0;
  localparam logic [POS_W-1:0]   POS_RESET       = 8'd125;
  localparam logic [POS_W-1:0]   INCREMENT_RESET = 8'd5;
  localparam logic [POS_W-1:0]   TARGET_RESET    = 8'd0;
  localparam logic [PHASE_W-1:0] PHASE_RESET     = 3'd0;
  localparam logic [COIL_W-1:0]  COILS_OFF       = 4'h0;

  // Opcode codes on the command channel.
  localparam logic [OPCODE_W-1:0] OP_SET_TARGET  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POS_TICK    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP_TICK   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_OUTER_LIMIT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_INNER_LIMIT = 3'd4;

  typedef enum logic [2:0] {
    CMD_SET_TARGET,
    CMD_POS_TICK,
    CMD_STEP_TICK,
    CMD_OUTER_LIMIT,
    CMD_INNER_LIMIT,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] target;
  } queue_entry_t;

  // Eight-phase half-step coil sequence.
  function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h8;
      3'd1:    pat = 4'hC;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'h3;
      3'd6:    pat = 4'h1;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  function automatic logic is_moving(input logic outward, input logic [POS_W-1:0] pos,
                                     input logic [POS_W-1:0] tgt);
    return outward ? (pos < tgt) : (pos > tgt);
  endfunction

endpackage

>>> hw/rtl/sps_if.sv
interface sps_cmd_if import sps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    target_value;

  modport source (output valid, output opcode, output target_value, input ready);
  modport sink   (input valid, input opcode, input target_value, output ready);
endinterface

interface sps_status_if import sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_pattern;
  logic [POS_W-1:0]  position;
  logic              moving;
  logic              direction_out;

  modport source (output valid, output coil_pattern, output position, output moving,
                  output direction_out, input ready);
  modport sink   (input valid, input coil_pattern, input position, input moving,
                  input direction_out, output ready);
endinterface

>>> hw/rtl/stepper_position_servo.sv
// Half-step stepper position servo. Each command transfer on cmd (opcode 0 set
// target, 1 position tick, 2 step tick, 3 outer limit, 4 inner limit, others
// no-op) yields exactly one status transfer carrying the coil drive pattern,
// the dead-reckoned position, the moving flag and the direction, in command
// order. The block sustains one command per clock while status is ready: a
// decoder feeds a two-entry queue, and an execution stage applies each
// command to the state registers and holds the result in an output register.
// A result passes through the queue and the output register before it is
// offered on status, and stays there until taken; a stalled status side
// fills the queue before cmd drops ready.
// After reset the position is 125, the target 0, the direction inward, the
// coils off and position_increment 5. Write position_increment through
// cfg_wen/cfg_wdata only while no command is in flight.
module stepper_position_servo import sps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [POS_W-1:0] cfg_wdata,
  sps_cmd_if.sink          cmd,
  sps_status_if.source     status
);

  logic [POS_W-1:0] increment;

  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_entry;

  // Hold the position increment; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      increment <= INCREMENT_RESET;
    end else if (cfg_wen) begin
      increment <= cfg_wdata;
    end
  end

  // Decode opcodes into commands.
  sps_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Decouple the decoder from the execution stage.
  sps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Execute commands against position, target, direction, phase and coils.
  sps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .increment (increment),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .status    (status)
  );

endmodule

>>> hw/rtl/sps_front.sv
module sps_front import sps_pkg::*; (
  sps_cmd_if.sink      cmd,
  output logic         push_valid,
  input  logic         push_ready,
  output queue_entry_t push_entry
);

  cmd_t cmd_kind;

  // Classify the opcode; unknown codes become no-ops.
  always_comb begin
    case (cmd.opcode)
      OP_SET_TARGET:  cmd_kind = CMD_SET_TARGET;
      OP_POS_TICK:    cmd_kind = CMD_POS_TICK;
      OP_STEP_TICK:   cmd_kind = CMD_STEP_TICK;
      OP_OUTER_LIMIT: cmd_kind = CMD_OUTER_LIMIT;
      OP_INNER_LIMIT: cmd_kind = CMD_INNER_LIMIT;
      default:        cmd_kind = CMD_NOP;
    endcase
  end

  assign push_valid        = cmd.valid;
  assign cmd.ready         = push_ready;
  assign push_entry.cmd    = cmd_kind;
  assign push_entry.target = cmd.target_value;

endmodule

>>> hw/rtl/sps_queue.sv
module sps_queue import sps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_entry
);

  queue_entry_t           slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/sps_back.sv
module sps_back import sps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] increment,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  queue_entry_t     pop_entry,
  sps_status_if.source     status
);

  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   target;
  logic               outward;
  logic [PHASE_W-1:0] phase;
  logic [COIL_W-1:0]  coils;

  logic [POS_W-1:0]   position_next;
  logic [POS_W-1:0]   target_next;
  logic               outward_next;
  logic [PHASE_W-1:0] phase_next;
  logic [COIL_W-1:0]  coils_next;

  logic               out_valid;
  logic               take;
  logic               moving_now;
  logic [POS_W:0]     pos_sum;

  // The output register frees when empty or when its result is taken.
  assign pop_ready  = !out_valid || status.ready;
  assign take       = pop_valid && pop_ready;
  assign moving_now = is_moving(outward, position, target);
  assign pos_sum    = {1'b0, position} + {1'b0, increment};

  always_comb begin
    position_next = position;
    target_next   = target;
    outward_next  = outward;
    phase_next    = phase;
    coils_next    = coils;
    case (pop_entry.cmd)
      CMD_SET_TARGET: begin
        target_next  = pop_entry.target;
        outward_next = (pop_entry.target > position);
      end
      CMD_POS_TICK: begin
        if (moving_now) begin
          if (outward) begin
            position_next = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
          end else begin
            position_next = (increment > position) ? POS_MIN : position - increment;
          end
        end
      end
      CMD_STEP_TICK: begin
        if (moving_now) begin
          coils_next = half_step_pattern(phase);
          phase_next = outward ? phase - 1'b1 : phase + 1'b1;
        end
      end
      CMD_OUTER_LIMIT: begin
        position_next = POS_MAX;
        outward_next  = 1'b0;
      end
      CMD_INNER_LIMIT: begin
        position_next = POS_MIN;
        outward_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= POS_RESET;
      target    <= TARGET_RESET;
      outward   <= 1'b0;
      phase     <= PHASE_RESET;
      coils     <= COILS_OFF;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        position  <= position_next;
        target    <= target_next;
        outward   <= outward_next;
        phase     <= phase_next;
        coils     <= coils_next;
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status.coil_pattern  <= coils_next;
      status.position      <= position_next;
      status.moving        <= is_moving(outward_next, position_next, target_next);
      status.direction_out <= outward_next;
    end
  end

  assign status.valid = out_valid;

endmodule

>>> sim/stepper_position_servo_tb.sv
module stepper_position_servo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  // Opcodes past the inner limit are spare: the block must report status and change nothing.
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  // Half-step coil sequence packed one nibble per phase, phase 0 in the low nibble.
  localparam logic [31:0] HALF_STEP_SEQ = 32'h9132_64C8;

  localparam int IDLE_PERCENT  = 6;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic [POS_W-1:0]  pos;
    logic              moving;
    logic              outward;
  } servo_status_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wen;
  logic [POS_W-1:0] cfg_wdata;

  sps_cmd_if    cmd_ch ();
  sps_status_if status_ch ();

  stepper_position_servo i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .status    (status_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the servo state, advanced once per accepted command transfer.
  logic [POS_W-1:0]   m_pos;
  logic [POS_W-1:0]   m_target;
  logic [POS_W-1:0]   m_incr;
  logic               m_outward;
  logic [PHASE_W-1:0] m_phase;
  logic [COIL_W-1:0]  m_coils;

  servo_status_t status_expected[$];
  int            mismatch_count = 0;
  bit            quiet = 1'b0;   // set: neither side idles

  // Motion continues while the position has not reached or passed the target.
  function automatic logic motion_pending();
    return m_outward ? (m_pos < m_target) : (m_pos > m_target);
  endfunction

  // Apply one command to the shadow state and return the status it must produce.
  function automatic servo_status_t apply_command(input logic [OPCODE_W-1:0] op,
                                                  input logic [POS_W-1:0] tv);
    logic [POS_W:0] sum;
    servo_status_t  st;
    case (op)
      OP_SET_TARGET: begin
        m_outward = tv > m_pos;
        m_target  = tv;
      end
      OP_POS_TICK: begin
        if (motion_pending()) begin
          if (m_outward) begin
            // Saturate at the top when the carry shows an overshoot.
            sum   = {1'b0, m_pos} + {1'b0, m_incr};
            m_pos = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
          end else begin
            m_pos = (m_incr > m_pos) ? POS_MIN : m_pos - m_incr;
          end
        end
      end
      OP_STEP_TICK: begin
        if (motion_pending()) begin
          // Latch the current phase pattern, then walk down outward, up inward.
          m_coils = HALF_STEP_SEQ[{m_phase, 2'b00} +: COIL_W];
          m_phase = m_outward ? m_phase - 3'd1 : m_phase + 3'd1;
        end
      end
      OP_OUTER_LIMIT: begin
        m_pos     = POS_MAX;
        m_outward = 1'b0;
      end
      OP_INNER_LIMIT: begin
        m_pos     = POS_MIN;
        m_outward = 1'b1;
      end
      default: ;
    endcase
    st.coils   = m_coils;
    st.pos     = m_pos;
    st.moving  = motion_pending();
    st.outward = m_outward;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Hold one command on cmd until it transfers, with an occasional idle gap in front.
  // Valid stays high on return so back-to-back commands go out at full rate.
  // Idle gaps open on about one item in forty.
  task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] tv);
    int gap;
    if (!quiet && $urandom_range(249) < IDLE_PERCENT) begin
      gap = $urandom_range(4, 1);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.target_value <= tv;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    status_expected.push_back(apply_command(op, tv));
  endtask

  // Drop valid and hold off until every outstanding status transfer has come back,
  // then let the pipeline settle. Anything still missing after the bound is a failure.
  task automatic wait_for_status_drain();
    int waited;
    waited = 0;
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (status_expected.size() != 0) begin
      report_mismatch($sformatf("%0d status transfers never arrived", status_expected.size()));
      status_expected.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write position_increment with nothing in flight.
  task automatic write_increment(input logic [POS_W-1:0] value);
    wait_for_status_drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    m_incr = value;
  endtask

  // Mostly target-then-ticks traffic so motion runs deep; limits and spare opcodes as noise.
  // Tick opcodes carry random target bits, which the block must ignore.
  task automatic send_random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12)
      send_command(OP_SET_TARGET, POS_W'($urandom_range(255)));
    else if (pick < 52)
      send_command(OP_POS_TICK, POS_W'($urandom));
    else if (pick < 88)
      send_command(OP_STEP_TICK, POS_W'($urandom));
    else if (pick < 92)
      send_command(OP_OUTER_LIMIT, POS_W'($urandom));
    else if (pick < 96)
      send_command(OP_INNER_LIMIT, POS_W'($urandom));
    else
      send_command(OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), POS_W'($urandom));
  endtask

  // Status right out of reset: position 125 above target 0, so inward and moving, coils off.
  task automatic test_reset_state();
    send_command(OP_SPARE_FIRST, '0);
    send_command(OP_SPARE_LAST, POS_MAX);
  endtask

  // Walk every opcode through moving and stopped states at the reset increment.
  task automatic test_directed_motion();
    send_command(OP_STEP_TICK, '0);       // first phase pattern, inward
    send_command(OP_POS_TICK, '0);        // 125 -> 120
    send_command(OP_SET_TARGET, POS_MAX); // reverse to outward
    send_command(OP_STEP_TICK, '0);       // phase walks back down
    send_command(OP_STEP_TICK, '0);       // wrap phase below zero
    send_command(OP_OUTER_LIMIT, '0);     // at 255 with target 255: stopped
    send_command(OP_POS_TICK, '0);        // stopped: no change
    send_command(OP_STEP_TICK, '0);       // stopped: coils hold the last pattern
    send_command(OP_SET_TARGET, POS_MIN);
    send_command(OP_INNER_LIMIT, '0);     // at 0 with target 0: stopped
    send_command(OP_SET_TARGET, POS_MIN); // target equal to position
    send_command(OP_SPARE_LAST, 8'hA5);
    send_command(OP_SET_TARGET, 8'd7);
    send_command(OP_POS_TICK, '0);        // 0 -> 5
    send_command(OP_POS_TICK, '0);        // passes 7 and stops at 10
  endtask

  // Both ends reached with the widest increment, then a zero and a unit increment.
  task automatic test_increment_extremes();
    write_increment(POS_MAX);
    send_command(OP_INNER_LIMIT, '0);
    send_command(OP_SET_TARGET, 8'd200);
    send_command(OP_POS_TICK, '0);        // lands on 255 exactly, past the target
    send_command(OP_SET_TARGET, 8'd1);
    send_command(OP_POS_TICK, '0);        // lands on 0 exactly, past the target
    write_increment('0);
    send_command(OP_SET_TARGET, 8'd100);
    send_command(OP_POS_TICK, '0);        // zero increment: position holds
    send_command(OP_STEP_TICK, '0);
    write_increment(8'd1);
    send_command(OP_POS_TICK, '0);
  endtask

  // Random phases, each at its own increment, with one full drain midway through each.
  task automatic test_random_traffic(input int phases, input int items_per_phase);
    logic [POS_W-1:0] inc;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0:       inc = 8'd1;
        1:       inc = POS_MAX;
        2:       inc = POS_W'($urandom_range(255, 1));
        default: inc = POS_W'($urandom_range(16, 1));
      endcase
      write_increment(inc);
      for (int i = 0; i < items_per_phase; i++) begin
        if (i == items_per_phase / 2)
          wait_for_status_drain();
        send_random_command();
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate(input int items);
    write_increment(POS_W'($urandom_range(8, 2)));
    quiet = 1'b1;
    for (int i = 0; i < items; i++)
      send_random_command();
    wait_for_status_drain();
    quiet = 1'b0;
  endtask

  // Compare each status transfer with the oldest expectation, then pick the next ready.
  always @(posedge clk) begin
    servo_status_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (status_expected.size() == 0) begin
        report_mismatch("status transfer with nothing outstanding");
      end else begin
        want = status_expected.pop_front();
        if (status_ch.coil_pattern !== want.coils)
          report_mismatch($sformatf("coil_pattern got %h want %h",
                                    status_ch.coil_pattern, want.coils));
        if (status_ch.position !== want.pos)
          report_mismatch($sformatf("position got %0d want %0d", status_ch.position, want.pos));
        if (status_ch.moving !== want.moving)
          report_mismatch($sformatf("moving got %b want %b", status_ch.moving, want.moving));
        if (status_ch.direction_out !== want.outward)
          report_mismatch($sformatf("direction_out got %b want %b",
                                    status_ch.direction_out, want.outward));
      end
    end
    status_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  initial begin
    rst                 <= 1'b1;
    cfg_wen             <= 1'b0;
    cfg_wdata           <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_SET_TARGET;
    cmd_ch.target_value <= '0;
    m_pos     = POS_RESET;
    m_target  = TARGET_RESET;
    m_incr    = INCREMENT_RESET;
    m_outward = 1'b0;
    m_phase   = PHASE_RESET;
    m_coils   = COILS_OFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_motion();
    test_increment_extremes();
    test_random_traffic(5, 80);
    test_full_rate(150);

    wait_for_status_drain();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_if.sv
hw/rtl/sps_front.sv
hw/rtl/sps_queue.sv
hw/rtl/sps_back.sv
hw/rtl/stepper_position_servo.sv
sim/stepper_position_servo_tb.sv
